/* rtl/core/spp_pkg.sv */
// Shared types, constants and sizes of the stereo ping-pong delay.
package spp_pkg;

    localparam int ECHO_DEPTH   = 12000;
    localparam int PTR_W        = $clog2(ECHO_DEPTH);

    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 22;
    localparam int SM_W     = 40;
    localparam int GAIN_W   = 24;
    localparam int FB_W     = 16;
    localparam int TGT_W    = 16;
    localparam int STEP_W   = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam int Q_BITS        = 20;
    localparam int DIV_PER_CYCLE = 5;
    localparam int DIV_CYCLES    = Q_BITS / DIV_PER_CYCLE;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
    localparam int MAG_W         = 26;
    localparam int REM_W         = 27;

    localparam logic [TGT_W-1:0]  GAIN_RESET     = 16'd7209;
    localparam logic [TGT_W-1:0]  FEEDBACK_RESET = 16'd26214;
    localparam logic [STEP_W-1:0] STEP_RESET     = 24'd776;

    localparam logic signed [16:0] K_SEND = 17'sd17039;
    localparam logic signed [16:0] K_WET  = 17'sd34079;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_STEP  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SCALE,
        S_MIX,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scale;
        logic mix;
        logic div;
    } t_lane_ctl;

    typedef struct packed {
        logic mul;
        logic upd;
    } t_smooth_ctl;

endpackage

/* rtl/core/spp_smoother.sv */
// One-pole smoother that moves a 40-bit value one step toward its target per word.
module spp_smoother (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spp_pkg::t_smooth_ctl        i_ctl,
    input  logic [spp_pkg::TGT_W-1:0]   i_init,
    input  logic [spp_pkg::TGT_W-1:0]   i_target,
    input  logic [spp_pkg::STEP_W-1:0]  i_step,
    output logic [spp_pkg::SM_W-1:0]    o_value
);

    logic [spp_pkg::SM_W-1:0]  r_value;
    logic [spp_pkg::SM_W-1:0]  n_value;
    logic [43:0]               r_p_hi;
    logic [43:0]               r_p_lo;
    logic                      r_neg;
    logic [spp_pkg::SM_W-1:0]  w_tgt;
    logic                      w_neg;
    logic [spp_pkg::SM_W-1:0]  w_mag;
    logic [63:0]               w_total;
    logic [spp_pkg::SM_W-1:0]  w_amt;

    always_comb begin
        w_tgt   = {i_target, 24'd0};
        w_neg   = r_value > w_tgt;
        w_mag   = w_neg ? (r_value - w_tgt) : (w_tgt - r_value);
        w_total = {r_p_hi, 20'd0} + {20'd0, r_p_lo};
        w_amt   = w_total[63:24];
        n_value = r_neg ? (r_value - w_amt) : (r_value + w_amt);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_p_hi <= {24'd0, w_mag[39:20]} * {20'd0, i_step};
            r_p_lo <= {24'd0, w_mag[19:0]} * {20'd0, i_step};
            r_neg  <= w_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= {i_init, 24'd0};
        end else if (i_ctl.upd) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

/* rtl/core/spp_lane.sv */
// One channel lane: echo line, gain scaling, delay send, wet mix and soft clip divider.
module spp_lane (
    input  logic                                 i_clk,
    input  spp_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [spp_pkg::SAMPLE_W-1:0]  i_dry,
    input  logic [spp_pkg::GAIN_W-1:0]           i_gain,
    input  logic [spp_pkg::FB_W-1:0]             i_fb,
    input  logic [spp_pkg::PTR_W-1:0]            i_ptr,
    input  logic                                 i_wrapped,
    input  logic signed [spp_pkg::SAMPLE_W-1:0]  i_wet_other,
    output logic signed [spp_pkg::SAMPLE_W-1:0]  o_wet,
    output logic signed [spp_pkg::OUT_W-1:0]     o_out
);

    logic signed [spp_pkg::SAMPLE_W-1:0] r_mem [spp_pkg::ECHO_DEPTH];
    logic signed [spp_pkg::SAMPLE_W-1:0] r_rd;
    logic signed [spp_pkg::SAMPLE_W-1:0] r_dry;
    logic signed [spp_pkg::SAMPLE_W-1:0] r_sl;
    logic [spp_pkg::REM_W-1:0]           r_rem;
    logic [spp_pkg::REM_W-1:0]           r_den;
    logic [spp_pkg::Q_BITS-1:0]          r_q;
    logic                                r_neg;

    logic signed [48:0]                  w_prod;
    logic signed [40:0]                  w_send_a;
    logic signed [40:0]                  w_send_b;
    logic signed [41:0]                  w_send_sum;
    logic signed [25:0]                  w_send_sh;
    logic signed [spp_pkg::SAMPLE_W-1:0] w_send;
    logic signed [40:0]                  w_wk;
    logic signed [25:0]                  w_x;
    logic [spp_pkg::MAG_W-1:0]           w_mag;
    logic [spp_pkg::REM_W-1:0]           n_rem;
    logic [spp_pkg::Q_BITS-1:0]          n_q;
    logic signed [spp_pkg::OUT_W-1:0]    w_qs;

    assign o_wet = i_wrapped ? r_rd : '0;

    always_comb begin
        w_prod     = r_dry * $signed({1'b0, i_gain});
        w_send_a   = r_sl * spp_pkg::K_SEND;
        w_send_b   = i_wet_other * $signed({1'b0, i_fb});
        w_send_sum = 42'(w_send_a) + 42'(w_send_b);
        w_send_sh  = w_send_sum[41:16];
        if (w_send_sh > 26'sd8388607) begin
            w_send = 24'sh7FFFFF;
        end else if (w_send_sh < -26'sd8388608) begin
            w_send = -24'sh800000;
        end else begin
            w_send = w_send_sh[23:0];
        end
        w_wk  = o_wet * spp_pkg::K_WET;
        w_x   = 26'(r_sl) + 26'($signed(w_wk[40:16]));
        w_mag = w_x[25] ? $unsigned(-w_x) : $unsigned(w_x);
    end

    always_comb begin
        logic [spp_pkg::REM_W:0]   t;
        logic [spp_pkg::REM_W-1:0] rem;
        logic [spp_pkg::Q_BITS-1:0] q;
        rem = r_rem;
        q   = r_q;
        for (int i = 0; i < spp_pkg::DIV_PER_CYCLE; i++) begin
            t = {rem, 1'b0};
            if (t >= {1'b0, r_den}) begin
                t   = t - {1'b0, r_den};
                q   = {q[spp_pkg::Q_BITS-2:0], 1'b1};
            end else begin
                q   = {q[spp_pkg::Q_BITS-2:0], 1'b0};
            end
            rem = t[spp_pkg::REM_W-1:0];
        end
        n_rem = rem;
        n_q   = q;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rd <= r_mem[i_ptr];
        end
        if (i_ctl.mix) begin
            r_mem[i_ptr] <= w_send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dry <= i_dry;
        end
        if (i_ctl.scale) begin
            r_sl <= w_prod[47:24];
        end
        if (i_ctl.mix) begin
            r_rem <= spp_pkg::REM_W'(w_mag);
            r_den <= spp_pkg::REM_W'(w_mag) + spp_pkg::REM_W'(1 << spp_pkg::Q_BITS);
            r_neg <= w_x[25];
            r_q   <= '0;
        end else if (i_ctl.div) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign w_qs  = spp_pkg::OUT_W'(r_q);
    assign o_out = r_neg ? -w_qs : w_qs;

endmodule

/* rtl/core/stereo_ping_pong_delay_unit.sv */
// The sequencer steps each accepted word through smoothing, scaling, delay send and the
// soft clip divider (5 quotient bits per cycle); a new word is taken only when it is idle,
// and the done state waits while the output register still holds an untaken result.
// The output register lets a new input word be taken while the previous result waits.
// Reset (synchronous, active low) restores the control and configuration registers,
// the smoothers and the pointer; echo entries read as zero until the pointer has passed them once, so no clearing pass.
module stereo_ping_pong_delay_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spp_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [47:0]                       s_axis_tdata,   // left dry, right dry
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [47:0]                       m_axis_tdata    // left_out, right_out, zeros
);

    spp_pkg::t_state                   r_state;
    spp_pkg::t_state                   n_state;
    logic [spp_pkg::TGT_W-1:0]         r_target_gain;
    logic [spp_pkg::TGT_W-1:0]         r_target_fb;
    logic [spp_pkg::STEP_W-1:0]        r_step;
    logic [spp_pkg::PTR_W-1:0]         r_ptr;
    logic                              r_wrapped;
    logic [spp_pkg::DIV_CNT_W-1:0]     r_div_cnt;
    logic                              r_out_valid;
    logic [47:0]                       r_out_data;

    logic                              w_accept;
    logic                              w_out_load;
    spp_pkg::t_lane_ctl                w_lane_ctl;
    spp_pkg::t_smooth_ctl              w_sm_ctl;
    logic [spp_pkg::SM_W-1:0]          w_sm_gain;
    logic [spp_pkg::SM_W-1:0]          w_sm_fb;
    logic signed [spp_pkg::SAMPLE_W-1:0] w_wet_l;
    logic signed [spp_pkg::SAMPLE_W-1:0] w_wet_r;
    logic signed [spp_pkg::OUT_W-1:0]  w_out_l;
    logic signed [spp_pkg::OUT_W-1:0]  w_out_r;
    logic                              w_div_last;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_div_last = r_div_cnt == spp_pkg::DIV_CNT_W'(spp_pkg::DIV_CYCLES - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            spp_pkg::S_IDLE:  if (s_axis_tvalid) n_state = spp_pkg::S_UPD;
            spp_pkg::S_UPD:   n_state = spp_pkg::S_SCALE;
            spp_pkg::S_SCALE: n_state = spp_pkg::S_MIX;
            spp_pkg::S_MIX:   n_state = spp_pkg::S_DIV;
            spp_pkg::S_DIV:   if (w_div_last) n_state = spp_pkg::S_DONE;
            spp_pkg::S_DONE:  if (!r_out_valid || m_axis_tready) n_state = spp_pkg::S_IDLE;
            default:          n_state = spp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = r_state == spp_pkg::S_IDLE;
        w_sm_ctl.mul     = w_accept;
        w_sm_ctl.upd     = r_state == spp_pkg::S_UPD;
        w_lane_ctl.load  = w_accept;
        w_lane_ctl.scale = r_state == spp_pkg::S_SCALE;
        w_lane_ctl.mix   = r_state == spp_pkg::S_MIX;
        w_lane_ctl.div   = r_state == spp_pkg::S_DIV;
        w_out_load       = (r_state == spp_pkg::S_DONE) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spp_pkg::S_IDLE;
            r_ptr       <= '0;
            r_wrapped   <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_lane_ctl.mix) begin
                r_div_cnt <= '0;
                if (r_ptr == spp_pkg::PTR_W'(spp_pkg::ECHO_DEPTH - 1)) begin
                    r_ptr     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end else if (w_lane_ctl.div) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_gain <= spp_pkg::GAIN_RESET;
            r_target_fb   <= spp_pkg::FEEDBACK_RESET;
            r_step        <= spp_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spp_pkg::CFG_TARGET_GAIN:     r_target_gain <= i_cfg_data[15:0];
                spp_pkg::CFG_TARGET_FEEDBACK: r_target_fb   <= i_cfg_data[15:0];
                spp_pkg::CFG_SMOOTHING_STEP:  r_step        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {4'd0, w_out_r, w_out_l};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    spp_smoother u_sm_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_sm_ctl),
        .i_init   (spp_pkg::GAIN_RESET),
        .i_target (r_target_gain),
        .i_step   (r_step),
        .o_value  (w_sm_gain)
    );

    spp_smoother u_sm_fb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_sm_ctl),
        .i_init   (spp_pkg::FEEDBACK_RESET),
        .i_target (r_target_fb),
        .i_step   (r_step),
        .o_value  (w_sm_fb)
    );

    spp_lane u_lane_l (
        .i_clk       (i_clk),
        .i_ctl       (w_lane_ctl),
        .i_dry       (s_axis_tdata[23:0]),
        .i_gain      (w_sm_gain[39:16]),
        .i_fb        (w_sm_fb[39:24]),
        .i_ptr       (r_ptr),
        .i_wrapped   (r_wrapped),
        .i_wet_other (w_wet_r),
        .o_wet       (w_wet_l),
        .o_out       (w_out_l)
    );

    spp_lane u_lane_r (
        .i_clk       (i_clk),
        .i_ctl       (w_lane_ctl),
        .i_dry       (s_axis_tdata[47:24]),
        .i_gain      (w_sm_gain[39:16]),
        .i_fb        (w_sm_fb[39:24]),
        .i_ptr       (r_ptr),
        .i_wrapped   (r_wrapped),
        .i_wet_other (w_wet_l),
        .o_wet       (w_wet_r),
        .o_out       (w_out_r)
    );

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == spp_pkg::S_UPD)
        else $error("Accepted word did not start the smoother update.");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spp_pkg::S_DIV && w_div_last) |=> r_state == spp_pkg::S_DONE)
        else $error("Divider did not finish after its fixed cycle count.");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_out_valid && r_state == spp_pkg::S_IDLE)
        else $error("Finished word was not placed in the output register.");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= spp_pkg::PTR_W'(spp_pkg::ECHO_DEPTH - 1))
        else $error("Echo pointer left the delay range.");

endmodule

/* bench/tb_stereo_ping_pong_delay_unit.sv */
// Self-checking testbench of the stereo ping-pong delay unit with soft clip output.
`timescale 1ns / 1ps

module tb_stereo_ping_pong_delay_unit;

    localparam longint LIMIT_CYCLES  = 3_000_000;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     TAIL_CHUNKS    = 2;
    localparam int     TAIL_CHUNK_LEN = 50;
    localparam longint SEND_GAIN     = spp_pkg::K_SEND;
    localparam longint WET_GAIN      = spp_pkg::K_WET;
    localparam logic [spp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [spp_pkg::SAMPLE_W-1:0] right;
        logic signed [spp_pkg::SAMPLE_W-1:0] left;
    } t_dry_frame;

    typedef struct packed {
        logic signed [spp_pkg::OUT_W-1:0] right;
        logic signed [spp_pkg::OUT_W-1:0] left;
    } t_mix_frame;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [spp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [spp_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [47:0]                   s_axis_tdata = '0;   // left dry, right dry
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [47:0]                   m_axis_tdata;        // left_out, right_out, zeros

    stereo_ping_pong_delay_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Mirror of the block state.
    logic [spp_pkg::TGT_W-1:0]           tgt_gain;
    logic [spp_pkg::TGT_W-1:0]           tgt_fb;
    logic [spp_pkg::STEP_W-1:0]          glide_step;
    longint                              gain_acc;
    longint                              fb_acc;
    logic signed [spp_pkg::SAMPLE_W-1:0] echo_l [spp_pkg::ECHO_DEPTH];
    logic signed [spp_pkg::SAMPLE_W-1:0] echo_r [spp_pkg::ECHO_DEPTH];
    int                                  echo_ptr;

    t_dry_frame dry_q[$];
    t_mix_frame mix_expect_q[$];
    bit         idling_on;
    int         src_gap;
    int         sink_stall;
    int         mismatch_count = 0;
    longint     words_seen = 0;
    longint     cycle_count = 0;
    t_mix_frame mix_want;
    t_mix_frame mix_got;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint glide(longint cur, logic [spp_pkg::TGT_W-1:0] tgt);
        longint          d;
        longint unsigned mag;
        longint unsigned inc;
        d   = (longint'(tgt) << 24) - cur;
        mag = (d < 0) ? -d : d;
        inc = (mag * glide_step) >> 24;
        return (d < 0) ? cur - longint'(inc) : cur + longint'(inc);
    endfunction

    function automatic longint sat_sample(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic longint clip_curve(longint x);
        longint unsigned mag;
        longint unsigned q;
        mag = (x < 0) ? -x : x;
        q   = (mag << spp_pkg::Q_BITS) / ((64'd1 << spp_pkg::Q_BITS) + mag);
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Advances the mirrored state by one frame and returns the mixed output.
    function automatic t_mix_frame step_delay_line(t_dry_frame f);
        longint     dl, dr, g24, fb16, sl, sr, wl, wr;
        t_mix_frame r;
        dl       = longint'($signed(f.left));
        dr       = longint'($signed(f.right));
        gain_acc = glide(gain_acc, tgt_gain);
        fb_acc   = glide(fb_acc, tgt_fb);
        g24      = gain_acc >>> 16;
        fb16     = fb_acc >>> 24;
        sl       = (dl * g24) >>> 24;
        sr       = (dr * g24) >>> 24;
        wl       = longint'(echo_l[echo_ptr]);
        wr       = longint'(echo_r[echo_ptr]);
        echo_l[echo_ptr] = spp_pkg::SAMPLE_W'(sat_sample((sl * SEND_GAIN + wr * fb16) >>> 16));
        echo_r[echo_ptr] = spp_pkg::SAMPLE_W'(sat_sample((sr * SEND_GAIN + wl * fb16) >>> 16));
        echo_ptr = (echo_ptr + 1 == spp_pkg::ECHO_DEPTH) ? 0 : echo_ptr + 1;
        r.left   = spp_pkg::OUT_W'(clip_curve((sl * 65536 + wl * WET_GAIN) >>> 16));
        r.right  = spp_pkg::OUT_W'(clip_curve((sr * 65536 + wr * WET_GAIN) >>> 16));
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint want, longint seen);
        mismatch_count++;
        $display("mismatch on %s of word %0d: expected %0d, got %0d",
                 what, words_seen, want, seen);
    endtask

    // Driver: presents queued frames with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                mix_expect_q.push_back(step_delay_line(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (dry_q.size() > 0) begin
                    s_axis_tdata  <= dry_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (idling_on && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 9);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every output word and stalls the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                words_seen++;
                if (mix_expect_q.size() == 0) begin
                    flag_mismatch("unexpected word", 0, longint'(m_axis_tdata));
                end else begin
                    mix_want = mix_expect_q.pop_front();
                    mix_got  = m_axis_tdata[2*spp_pkg::OUT_W-1:0];
                    if (mix_got.left !== mix_want.left)
                        flag_mismatch("left_out", mix_want.left, mix_got.left);
                    if (mix_got.right !== mix_want.right)
                        flag_mismatch("right_out", mix_want.right, mix_got.right);
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [spp_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return spp_pkg::SAMPLE_W'($urandom_range(0, 8191) - 4096);
            default: return spp_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_frame(logic [spp_pkg::SAMPLE_W-1:0] l,
                              logic [spp_pkg::SAMPLE_W-1:0] r);
        t_dry_frame f;
        f.left  = l;
        f.right = r;
        dry_q.push_back(f);
    endtask

    task automatic load_random(int count);
        repeat (count) push_frame(random_sample(), random_sample());
    endtask

    task automatic drain();
        while (dry_q.size() > 0 || s_axis_tvalid || mix_expect_q.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [spp_pkg::CFG_IDX_W-1:0] idx,
                             logic [spp_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            spp_pkg::CFG_TARGET_GAIN:     tgt_gain   = data[spp_pkg::TGT_W-1:0];
            spp_pkg::CFG_TARGET_FEEDBACK: tgt_fb     = data[spp_pkg::TGT_W-1:0];
            spp_pkg::CFG_SMOOTHING_STEP:  glide_step = data[spp_pkg::STEP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [spp_pkg::CFG_W-1:0] gain, logic [spp_pkg::CFG_W-1:0] fb,
                             logic [spp_pkg::CFG_W-1:0] stp, int count);
        write_reg(spp_pkg::CFG_TARGET_GAIN, gain);
        write_reg(spp_pkg::CFG_TARGET_FEEDBACK, fb);
        write_reg(spp_pkg::CFG_SMOOTHING_STEP, stp);
        load_random(count);
        drain();
    endtask

    initial begin
        tgt_gain   = spp_pkg::GAIN_RESET;
        tgt_fb     = spp_pkg::FEEDBACK_RESET;
        glide_step = spp_pkg::STEP_RESET;
        gain_acc   = longint'(spp_pkg::GAIN_RESET) << 24;
        fb_acc     = longint'(spp_pkg::FEEDBACK_RESET) << 24;
        echo_ptr   = 0;
        for (int i = 0; i < spp_pkg::ECHO_DEPTH; i++) begin
            echo_l[i] = '0;
            echo_r[i] = '0;
        end
        idling_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: sample extremes and bit patterns first.
        push_frame(24'h000000, 24'h000000);
        push_frame(24'h7FFFFF, 24'h7FFFFF);
        push_frame(24'h800000, 24'h800000);
        push_frame(24'h7FFFFF, 24'h800000);
        push_frame(24'h800000, 24'h7FFFFF);
        push_frame(24'h000001, 24'hFFFFFF);
        push_frame(24'hFFFFFF, 24'h000001);
        push_frame(24'h555555, 24'hAAAAAA);
        push_frame(24'hAAAAAA, 24'h555555);
        push_frame(24'h100000, 24'hF00000);
        push_frame(24'h3FFFFF, 24'hC00000);
        push_frame(24'h400000, 24'hBFFFFF);
        load_random(150);
        drain();

        // Full targets with the fastest glide, then a frozen glide with zero targets
        // whose gain write carries bits above the register width.
        run_phase(24'h00FFFF, 24'h00FFFF, 24'hFFFFFF, 200);
        run_phase(24'hFF0000, 24'h000000, 24'h000000, 150);

        // A write to the unused index must change nothing.
        write_reg(CFG_UNUSED, 24'h5A5A5A);
        run_phase(24'hA58000, 24'h5A4000, 24'h010000, 250);
        run_phase(24'h001234, 24'h00FFFF, 24'h000001, 150);
        repeat (2) run_phase(spp_pkg::CFG_W'($urandom), spp_pkg::CFG_W'($urandom),
                             spp_pkg::CFG_W'($urandom), 200);

        // Closing streams, full targets then random settings, the last without idling.
        for (int k = 0; k < TAIL_CHUNKS; k++) begin
            if (k == TAIL_CHUNKS - 1)
                idling_on = 1'b0;
            if (k % 2 == 0)
                run_phase(24'h00FFFF, 24'h00FFFF, 24'hFFFFFF, TAIL_CHUNK_LEN);
            else
                run_phase(spp_pkg::CFG_W'($urandom), spp_pkg::CFG_W'($urandom),
                          spp_pkg::CFG_W'($urandom_range(0, 24'hFFFFFF)), TAIL_CHUNK_LEN);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
